// ===== rtl/core/wavh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// wavh_pkg
// Shared types, codes and constants of the WAV header parser.
// -----------------------------------------------------------------------------
package wavh_pkg;

  localparam int DivNumW = 42;
  localparam int DivDenW = 32;
  localparam int DivCntW = $clog2(DivNumW);

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_IEEE_FLOAT = 16'd3;
  localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;
  localparam logic [31:0] SUBTAG_FLOAT   = 32'd3;
  localparam logic [31:0] FMT_MIN_SIZE   = 32'd16;
  localparam logic [31:0] FMT_EXT_SIZE   = 32'd40;
  localparam logic [31:0] FMT_EXT_SKIP   = 32'd28;
  localparam logic [41:0] MS_PER_S       = 42'd1000;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_RIFF   = 3'd1;
  localparam logic [2:0] ST_NO_WAVE   = 3'd2;
  localparam logic [2:0] ST_FMT_SHORT = 3'd3;
  localparam logic [2:0] ST_NO_FMT    = 3'd4;
  localparam logic [2:0] ST_TRUNC     = 3'd5;

  typedef enum logic [10:0] {
    PH_IDLE  = 11'b000_0000_0001,
    PH_RIFF  = 11'b000_0000_0010,
    PH_RSIZE = 11'b000_0000_0100,
    PH_WAVE  = 11'b000_0000_1000,
    PH_TAG   = 11'b000_0001_0000,
    PH_SIZE  = 11'b000_0010_0000,
    PH_FMT   = 11'b000_0100_0000,
    PH_EXT   = 11'b000_1000_0000,
    PH_SKIP  = 11'b001_0000_0000,
    PH_PAD   = 11'b010_0000_0000,
    PH_DONE  = 11'b100_0000_0000
  } phase_t;

  typedef enum logic [6:0] {
    RS_IDLE = 7'b000_0001,
    RS_ST1  = 7'b000_0010,
    RS_D1   = 7'b000_0100,
    RS_MUL  = 7'b000_1000,
    RS_ST2  = 7'b001_0000,
    RS_D2   = 7'b010_0000,
    RS_OUT  = 7'b100_0000
  } rstate_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_FMT   = 2'd1,
    KIND_DATA  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CNT_HOLD = 3'd0,
    CNT_INC  = 3'd1,
    CNT_CLR  = 3'd2,
    CNT_LOAD = 3'd3,
    CNT_DEC  = 3'd4
  } cnt_op_t;

  typedef enum logic [1:0] {
    SRC_GSZ = 2'd0,
    SRC_M16 = 2'd1,
    SRC_M28 = 2'd2
  } cnt_src_t;

  typedef struct packed {
    logic       clear;
    logic       gather;
    cnt_op_t    cnt_op;
    cnt_src_t   cnt_src;
    logic       load_size;
    logic       fmt_clr;
    logic       fmt_byte;
    logic       fmt_done;
    logic       ext_done;
    logic       res_load;
    logic [2:0] res_code;
    logic       div_start;
    logic       div_sel;
    logic       mul_load;
    logic       len_load;
  } dp_cmd_t;

  typedef struct packed {
    logic last4;
    logic fmt_last;
    logic ext_last;
    logic skip_last;
    logic tag_riff;
    logic tag_wave;
    logic tag_fmt;
    logic tag_data;
    logic gsz_zero;
    logic gsz_lt16;
    logic fmt_ext;
    logic m16_zero;
    logic m28_zero;
    logic size_odd;
    logic fmt_seen;
    logic len_zero;
    logic div_done;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/wavh_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// wavh_div
// Restoring divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module wavh_div
  import wavh_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [DivNumW-1:0] dividend,
  input  wire logic [DivDenW-1:0] divisor,
  output logic                    done,
  output logic [DivNumW-1:0]      quotient
);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;
  logic [DivDenW-1:0] rem_r, rem_nxt;
  logic [DivNumW-1:0] q_r, q_nxt;
  logic [DivDenW-1:0] dsr_r, dsr_nxt;
  logic [DivDenW:0]   rem_sh;
  logic               ge;

  // Operand load on start, else one shift-and-subtract step while busy.
  always_comb begin
    rem_sh   = {rem_r, q_r[DivNumW-1]};
    ge       = (rem_sh >= {1'b0, dsr_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? DivDenW'(rem_sh - {1'b0, dsr_r}) : rem_sh[DivDenW-1:0];
      q_nxt   = {q_r[DivNumW-2:0], ge};
      cnt_nxt = DivCntW'(cnt_r + 1'b1);
      if (cnt_r == DivCntW'(DivNumW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

// ===== rtl/core/wavh_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// wavh_dpath
// Byte gathering, chunk counters, kept format fields and result registers.
// -----------------------------------------------------------------------------
module wavh_dpath
  import wavh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  byte_in,
  input  wire dp_cmd_t     cmd,
  output dp_sts_t          sts,
  output logic [2:0]       res_status,
  output logic [15:0]      res_channels,
  output logic [31:0]      res_rate,
  output logic [15:0]      res_bits,
  output logic             res_float,
  output logic [31:0]      res_payload,
  output logic [41:0]      res_length
);

  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] gth_r, gth_nxt;
  logic [31:0] size_r;
  logic [15:0] code_r;
  logic [15:0] ch_r;
  logic [31:0] rate_r;
  logic [15:0] bits_r;
  logic        flt_r;
  logic        seen_r;
  logic [31:0] cnt_e, gth_e, load_val;

  logic [2:0]  st_r;
  logic [15:0] och_r;
  logic [31:0] orate_r;
  logic [15:0] obits_r;
  logic        oflt_r;
  logic [31:0] opay_r;
  logic [41:0] olen_r;
  logic [41:0] prod_r;

  logic [28:0]        frame;
  logic [DivNumW-1:0] div_num;
  logic [DivDenW-1:0] div_den;
  logic               div_done;
  logic [DivNumW-1:0] div_q;

  function automatic logic [28:0] ch_r_mul(input logic [15:0] c, input logic [15:0] b);
    ch_r_mul = {13'd0, c} * {16'd0, b[15:3]};
  endfunction

  // A file start clears the working state under the first byte.
  always_comb begin
    cnt_e   = cmd.clear ? '0 : cnt_r;
    gth_e   = cmd.clear ? '0 : gth_r;
    gth_nxt = cmd.gather ? {byte_in, gth_e[31:8]} : gth_e;
    unique case (cmd.cnt_src)
      SRC_M16: load_val = size_r - FMT_MIN_SIZE;
      SRC_M28: load_val = size_r - FMT_EXT_SKIP;
      default: load_val = gth_nxt;
    endcase
    unique case (cmd.cnt_op)
      CNT_INC:  cnt_nxt = cnt_e + 32'd1;
      CNT_CLR:  cnt_nxt = '0;
      CNT_LOAD: cnt_nxt = load_val;
      CNT_DEC:  cnt_nxt = cnt_e - 32'd1;
      default:  cnt_nxt = cnt_e;
    endcase
  end

  // Status flags for the controller.
  always_comb begin
    sts.last4     = (cnt_e == 32'd3);
    sts.fmt_last  = (cnt_e == 32'd15);
    sts.ext_last  = (cnt_e == 32'd11);
    sts.skip_last = (cnt_e <= 32'd1);
    sts.tag_riff  = (gth_nxt == TAG_RIFF);
    sts.tag_wave  = (gth_nxt == TAG_WAVE);
    sts.tag_fmt   = (gth_nxt == TAG_FMT);
    sts.tag_data  = (gth_nxt == TAG_DATA);
    sts.gsz_zero  = (gth_nxt == 32'd0);
    sts.gsz_lt16  = (gth_nxt < FMT_MIN_SIZE);
    sts.fmt_ext   = (code_r == FMT_EXTENSIBLE) && (size_r >= FMT_EXT_SIZE);
    sts.m16_zero  = (size_r == FMT_MIN_SIZE);
    sts.m28_zero  = (size_r == FMT_EXT_SKIP);
    sts.size_odd  = size_r[0];
    sts.fmt_seen  = seen_r;
    sts.len_zero  = (ch_r == 16'd0) || (bits_r[15:3] == 13'd0) || (rate_r == 32'd0);
    sts.div_done  = div_done;
  end

  // Parsing registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      gth_r  <= '0;
      size_r <= '0;
      code_r <= '0;
      ch_r   <= '0;
      rate_r <= '0;
      bits_r <= '0;
      flt_r  <= 1'b0;
      seen_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      gth_r <= gth_nxt;
      if (cmd.clear) begin
        size_r <= '0;
        code_r <= '0;
        ch_r   <= '0;
        rate_r <= '0;
        bits_r <= '0;
        flt_r  <= 1'b0;
        seen_r <= 1'b0;
      end
      if (cmd.load_size) begin
        size_r <= gth_nxt;
      end
      if (cmd.fmt_clr) begin
        code_r <= '0;
        ch_r   <= '0;
        rate_r <= '0;
        bits_r <= '0;
      end
      if (cmd.fmt_byte) begin
        unique case (cnt_r[3:0])
          4'd0:    code_r[7:0]    <= byte_in;
          4'd1:    code_r[15:8]   <= byte_in;
          4'd2:    ch_r[7:0]      <= byte_in;
          4'd3:    ch_r[15:8]     <= byte_in;
          4'd4:    rate_r[7:0]    <= byte_in;
          4'd5:    rate_r[15:8]   <= byte_in;
          4'd6:    rate_r[23:16]  <= byte_in;
          4'd7:    rate_r[31:24]  <= byte_in;
          4'd14:   bits_r[7:0]    <= byte_in;
          4'd15:   bits_r[15:8]   <= byte_in;
          default: ;
        endcase
      end
      if (cmd.fmt_done) begin
        seen_r <= 1'b1;
        flt_r  <= (code_r == FMT_IEEE_FLOAT);
      end
      if (cmd.ext_done) begin
        flt_r <= (gth_nxt == SUBTAG_FLOAT);
      end
    end
  end

  // Duration: payload / frame, times 1000, then / rate on the shared divider.
  assign frame   = ch_r_mul(och_r, obits_r);
  assign div_num = cmd.div_sel ? prod_r : {10'd0, opay_r};
  assign div_den = cmd.div_sel ? orate_r : {3'd0, frame};

  wavh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  // Result registers; error results carry zero fields.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      st_r <= cmd.res_code;
      if (cmd.res_code == ST_OK) begin
        och_r   <= ch_r;
        orate_r <= rate_r;
        obits_r <= bits_r;
        oflt_r  <= flt_r;
        opay_r  <= gth_nxt;
      end else begin
        och_r   <= '0;
        orate_r <= '0;
        obits_r <= '0;
        oflt_r  <= 1'b0;
        opay_r  <= '0;
      end
      olen_r <= '0;
    end
    if (cmd.mul_load) begin
      prod_r <= {10'd0, div_q[31:0]} * MS_PER_S;
    end
    if (cmd.len_load) begin
      olen_r <= div_q;
    end
  end

  assign res_status   = st_r;
  assign res_channels = och_r;
  assign res_rate     = orate_r;
  assign res_bits     = obits_r;
  assign res_float    = oflt_r;
  assign res_payload  = opay_r;
  assign res_length   = olen_r;

endmodule
`default_nettype wire

// ===== rtl/core/wavh_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// wavh_ctrl
// Chunk-walking phase machine and result sequencer.
// -----------------------------------------------------------------------------
module wavh_ctrl
  import wavh_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    file_start,
  input  wire logic    file_end,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  phase_t  ph_r, ph_nxt, ph_e;
  rstate_t rs_r, rs_nxt;
  kind_t   kind_r, kind_nxt;
  logic    acc;
  logic    err;
  logic [2:0] code;

  assign in_ready  = (rs_r == RS_IDLE);
  assign out_valid = (rs_r == RS_OUT);
  assign acc       = in_valid && in_ready;

  // Per-request phase step, then result sequencing.
  always_comb begin
    cmd      = '0;
    cmd.cnt_op  = CNT_HOLD;
    cmd.cnt_src = SRC_GSZ;
    ph_nxt   = ph_r;
    kind_nxt = kind_r;
    rs_nxt   = rs_r;
    err      = 1'b0;
    code     = ST_TRUNC;
    ph_e     = file_start ? PH_RIFF : ph_r;
    if (acc) begin
      if (file_start) begin
        cmd.clear = 1'b1;
        kind_nxt  = KIND_OTHER;
        ph_nxt    = PH_RIFF;
      end
      unique case (ph_e)
        PH_RIFF, PH_WAVE: begin
          cmd.gather = 1'b1;
          cmd.cnt_op = CNT_INC;
          if (sts.last4) begin
            if ((ph_e == PH_RIFF) ? !sts.tag_riff : !sts.tag_wave) begin
              err  = 1'b1;
              code = (ph_e == PH_RIFF) ? ST_NO_RIFF : ST_NO_WAVE;
            end else begin
              cmd.cnt_op = CNT_CLR;
              ph_nxt     = (ph_e == PH_RIFF) ? PH_RSIZE : PH_TAG;
            end
          end
        end
        PH_RSIZE: begin
          cmd.cnt_op = CNT_INC;
          if (sts.last4) begin
            cmd.cnt_op = CNT_CLR;
            ph_nxt     = PH_WAVE;
          end
        end
        PH_TAG: begin
          cmd.gather = 1'b1;
          cmd.cnt_op = CNT_INC;
          if (sts.last4) begin
            kind_nxt   = sts.tag_fmt ? KIND_FMT : (sts.tag_data ? KIND_DATA : KIND_OTHER);
            cmd.cnt_op = CNT_CLR;
            ph_nxt     = PH_SIZE;
          end
        end
        PH_SIZE: begin
          cmd.gather = 1'b1;
          cmd.cnt_op = CNT_INC;
          if (sts.last4) begin
            cmd.load_size = 1'b1;
            cmd.cnt_op    = CNT_CLR;
            unique case (kind_r)
              KIND_FMT: begin
                if (sts.gsz_lt16) begin
                  err  = 1'b1;
                  code = ST_FMT_SHORT;
                end else begin
                  cmd.fmt_clr = 1'b1;
                  ph_nxt      = PH_FMT;
                end
              end
              KIND_DATA: begin
                err  = 1'b1;
                code = sts.fmt_seen ? ST_OK : ST_NO_FMT;
              end
              default: begin
                if (sts.gsz_zero) begin
                  ph_nxt = PH_TAG;
                end else begin
                  cmd.cnt_op  = CNT_LOAD;
                  cmd.cnt_src = SRC_GSZ;
                  ph_nxt      = PH_SKIP;
                end
              end
            endcase
          end
        end
        PH_FMT: begin
          cmd.fmt_byte = 1'b1;
          cmd.cnt_op   = CNT_INC;
          if (sts.fmt_last) begin
            cmd.fmt_done = 1'b1;
            cmd.cnt_op   = CNT_CLR;
            if (sts.fmt_ext) begin
              ph_nxt = PH_EXT;
            end else if (sts.m16_zero) begin
              ph_nxt = sts.size_odd ? PH_PAD : PH_TAG;
            end else begin
              cmd.cnt_op  = CNT_LOAD;
              cmd.cnt_src = SRC_M16;
              ph_nxt      = PH_SKIP;
            end
          end
        end
        PH_EXT: begin
          cmd.gather = 1'b1;
          cmd.cnt_op = CNT_INC;
          if (sts.ext_last) begin
            cmd.ext_done = 1'b1;
            if (sts.m28_zero) begin
              cmd.cnt_op = CNT_CLR;
              ph_nxt     = sts.size_odd ? PH_PAD : PH_TAG;
            end else begin
              cmd.cnt_op  = CNT_LOAD;
              cmd.cnt_src = SRC_M28;
              ph_nxt      = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (sts.skip_last) begin
            cmd.cnt_op = CNT_CLR;
            ph_nxt     = sts.size_odd ? PH_PAD : PH_TAG;
          end else begin
            cmd.cnt_op = CNT_DEC;
          end
        end
        PH_PAD: begin
          cmd.cnt_op = CNT_CLR;
          ph_nxt     = PH_TAG;
        end
        default: ;
      endcase
      // A result ends the file: an error, a data chunk size or a truncated file.
      if ((ph_e != PH_IDLE) && (ph_e != PH_DONE) && (err || file_end)) begin
        cmd.res_load = 1'b1;
        cmd.res_code = code;
        ph_nxt       = PH_DONE;
      end
    end

    // Result sequencing through the duration computation.
    unique case (rs_r)
      RS_IDLE: begin
        if (cmd.res_load) begin
          rs_nxt = ((cmd.res_code == ST_OK) && !sts.len_zero) ? RS_ST1 : RS_OUT;
        end
      end
      RS_ST1: begin
        cmd.div_start = 1'b1;
        rs_nxt        = RS_D1;
      end
      RS_D1: begin
        if (sts.div_done) begin
          rs_nxt = RS_MUL;
        end
      end
      RS_MUL: begin
        cmd.mul_load = 1'b1;
        rs_nxt       = RS_ST2;
      end
      RS_ST2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
        rs_nxt        = RS_D2;
      end
      RS_D2: begin
        cmd.div_sel = 1'b1;
        if (sts.div_done) begin
          cmd.len_load = 1'b1;
          rs_nxt       = RS_OUT;
        end
      end
      RS_OUT: begin
        if (out_ready) begin
          rs_nxt = RS_IDLE;
        end
      end
      default: rs_nxt = RS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      rs_r   <= RS_IDLE;
      kind_r <= KIND_OTHER;
    end else begin
      ph_r   <= ph_nxt;
      rs_r   <= rs_nxt;
      kind_r <= kind_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/wav_header_chunk_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// wav_header_chunk_parser
// Parses a RIFF/WAVE header byte by byte and reports format and duration.
// -----------------------------------------------------------------------------
//   Channel | Direction | Handshake           | Payload
//   in_     | input     | in_valid/in_ready   | byte_value, file_start, file_end
//   out_    | output    | out_valid/out_ready | status, format fields, length
//
// One byte is taken per cycle while no result is pending.
// A result without a duration is ready the cycle after its last byte; an ok
// result with a duration waits for two passes of the 42-step serial divider.
// While a result waits for out_ready, in_ready stays low.
// Synchronous active-low reset returns the parser to waiting for a file start.
module wav_header_chunk_parser
  import wavh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte_value,
  input  wire logic        in_file_start,
  input  wire logic        in_file_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [15:0]      out_channel_count,
  output logic [31:0]      out_rate_hz,
  output logic [15:0]      out_sample_bits,
  output logic             out_float_flag,
  output logic [31:0]      out_payload_bytes,
  output logic [41:0]      out_length_ms
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Phase machine and result sequencer.
  wavh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .file_start (in_file_start),
    .file_end   (in_file_end),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Parsing registers, divider and result registers.
  wavh_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_in      (in_byte_value),
    .cmd          (cmd),
    .sts          (sts),
    .res_status   (out_status),
    .res_channels (out_channel_count),
    .res_rate     (out_rate_hz),
    .res_bits     (out_sample_bits),
    .res_float    (out_float_flag),
    .res_payload  (out_payload_bytes),
    .res_length   (out_length_ms)
  );

endmodule
`default_nettype wire

// ===== rtl/core/wavh_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// wavh_checker
// Port-level checks of the WAV header parser, bound to the top level.
// -----------------------------------------------------------------------------
module wavh_checker
  import wavh_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  out_status,
  input wire logic [15:0] out_channel_count,
  input wire logic [31:0] out_rate_hz,
  input wire logic [31:0] out_payload_bytes,
  input wire logic [41:0] out_length_ms
);

  // A pending result holds its status and length.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_length_ms))
    else $error("result changed while stalled");

  // No new request is taken while a result waits.
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // Status codes stay in range.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_TRUNC)
    else $error("status out of range");

  // Error results carry zero fields.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_channel_count == 16'd0 && out_rate_hz == 32'd0 &&
      out_payload_bytes == 32'd0 && out_length_ms == 42'd0)
    else $error("error result with nonzero fields");

endmodule

bind wav_header_chunk_parser wavh_checker u_wavh_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_channel_count (out_channel_count),
  .out_rate_hz       (out_rate_hz),
  .out_payload_bytes (out_payload_bytes),
  .out_length_ms     (out_length_ms)
);
`default_nettype wire
